@@ rtl/core/sfrt_pkg.sv @@
package sfrt_pkg;

  localparam int NUM_PROCESSES     = 256;
  localparam int RULES_PER_PROCESS = 16;

  localparam int SYSCALL_W = 16;
  localparam int VERDICT_W = 32;
  localparam int RULE_W    = SYSCALL_W + VERDICT_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [31:0] ALLOW_CODE_RST = 32'h7FFF_0000;
  localparam logic [31:0] KILL_CODE_RST  = 32'h0000_0000;

  localparam logic [CFG_IDX_W-1:0] REG_ALLOW_CODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KILL_CODE  = 2'd1;

  localparam logic [1:0] ACT_SET_MODE = 2'd0;
  localparam logic [1:0] ACT_ADD_RULE = 2'd1;
  localparam logic [1:0] ACT_CHECK    = 2'd2;
  localparam logic [1:0] ACT_GET_MODE = 2'd3;

  localparam logic [1:0] MODE_DISABLED = 2'd0;
  localparam logic [1:0] MODE_STRICT   = 2'd1;
  localparam logic [1:0] MODE_FILTER   = 2'd2;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    OP_REJECT       = 4'd0,
    OP_SET_STRICT   = 4'd1,
    OP_SET_FILTER   = 4'd2,
    OP_SET_DISABLED = 4'd3,
    OP_ADD          = 4'd4,
    OP_CHECK        = 4'd5,
    OP_ALLOW        = 4'd6,
    OP_GET          = 4'd7,
    OP_GET_NONE     = 4'd8
  } op_e;

  typedef struct packed {
    op_e                  op;
    logic [15:0]          pid;
    logic [SYSCALL_W-1:0] syscall;
    logic [VERDICT_W-1:0] rule_verdict;
  } req_t;

  typedef struct packed {
    logic [VERDICT_W-1:0] allow_code;
    logic [VERDICT_W-1:0] kill_code;
  } cfg_t;

  function automatic logic [SYSCALL_W-1:0] strict_syscall(input logic [1:0] idx);
    logic [SYSCALL_W-1:0] sc;
    case (idx)
      2'd0:    sc = 16'd1;
      2'd1:    sc = 16'd2;
      2'd2:    sc = 16'd0;
      default: sc = 16'd119;
    endcase
    return sc;
  endfunction

endpackage

@@ rtl/core/syscall_filter_rule_table.sv @@
// channel  | handshake                  | payload
// in       | in_valid_i / in_ready_o    | action_i pid_i mode_i syscall_number_i rule_verdict_i
// out      | out_valid_o / out_ready_i  | status_o verdict_o current_mode_o
// cfg      | cfg_valid_i / cfg_ready_o  | cfg_index_i cfg_data_i
//
// one item at a time in the back end; a two-entry queue decouples input acceptance
// set mode, add rule, get mode: queue pop, look-up, response; strict load adds four rule writes
// check: queue pop, look-up, in strict or filter mode a scan of the n stored rules (up to RulesPerProcess),
//   one rule ram read per cycle sets the scan length
// after reset a clearing pass over all NumProcesses entries empties the mode/count ram;
//   no item is accepted during it, configuration writes always are
// a stalled output holds the result; the queue keeps taking items until full
module syscall_filter_rule_table #(
  parameter int NumProcesses    = sfrt_pkg::NUM_PROCESSES,
  parameter int RulesPerProcess = sfrt_pkg::RULES_PER_PROCESS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     action_i,
  input  logic [15:0]                    pid_i,
  input  logic [1:0]                     mode_i,
  input  logic [sfrt_pkg::SYSCALL_W-1:0] syscall_number_i,
  input  logic [sfrt_pkg::VERDICT_W-1:0] rule_verdict_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     status_o,
  output logic [sfrt_pkg::VERDICT_W-1:0] verdict_o,
  output logic [1:0]                     current_mode_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sfrt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sfrt_pkg::VERDICT_W-1:0] cfg_data_i
);

  sfrt_pkg::cfg_t cfg_q, cfg_d;
  sfrt_pkg::req_t q_head;
  logic           q_valid;
  logic           q_pop;
  logic           clearing;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        sfrt_pkg::REG_ALLOW_CODE: cfg_d.allow_code = cfg_data_i;
        sfrt_pkg::REG_KILL_CODE:  cfg_d.kill_code  = cfg_data_i;
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.allow_code <= sfrt_pkg::ALLOW_CODE_RST;
      cfg_q.kill_code  <= sfrt_pkg::KILL_CODE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sfrt_front #(.NumProcesses(NumProcesses)) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .pid_i            (pid_i),
    .mode_i           (mode_i),
    .syscall_number_i (syscall_number_i),
    .rule_verdict_i   (rule_verdict_i),
    .hold_i           (clearing),
    .q_valid_o        (q_valid),
    .q_head_o         (q_head),
    .q_pop_i          (q_pop)
  );

  sfrt_back #(
    .NumProcesses    (NumProcesses),
    .RulesPerProcess (RulesPerProcess)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_valid_i      (q_valid),
    .q_head_i       (q_head),
    .q_pop_o        (q_pop),
    .clearing_o     (clearing),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .verdict_o      (verdict_o),
    .current_mode_o (current_mode_o)
  );

endmodule

@@ rtl/core/sfrt_ram.sv @@
module sfrt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/sfrt_front.sv @@
module sfrt_front #(
  parameter int NumProcesses = sfrt_pkg::NUM_PROCESSES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     action_i,
  input  logic [15:0]                    pid_i,
  input  logic [1:0]                     mode_i,
  input  logic [sfrt_pkg::SYSCALL_W-1:0] syscall_number_i,
  input  logic [sfrt_pkg::VERDICT_W-1:0] rule_verdict_i,
  input  logic                           hold_i,
  output logic                           q_valid_o,
  output sfrt_pkg::req_t                 q_head_o,
  input  logic                           q_pop_i
);

  sfrt_pkg::req_t req;
  sfrt_pkg::req_t ent_q [2];
  logic           in_range;
  logic           push;
  logic           wr_q, wr_d;
  logic           rd_q, rd_d;
  logic [1:0]     cnt_q, cnt_d;

  assign in_range = {1'b0, pid_i} < 17'(NumProcesses);

  always_comb begin
    req.pid          = pid_i;
    req.syscall      = syscall_number_i;
    req.rule_verdict = rule_verdict_i;
    req.op           = sfrt_pkg::OP_REJECT;
    case (action_i)
      sfrt_pkg::ACT_SET_MODE: begin
        if (in_range) begin
          case (mode_i)
            sfrt_pkg::MODE_STRICT:   req.op = sfrt_pkg::OP_SET_STRICT;
            sfrt_pkg::MODE_FILTER:   req.op = sfrt_pkg::OP_SET_FILTER;
            sfrt_pkg::MODE_DISABLED: req.op = sfrt_pkg::OP_SET_DISABLED;
            default:                 req.op = sfrt_pkg::OP_REJECT;
          endcase
        end
      end
      sfrt_pkg::ACT_ADD_RULE: begin
        req.op = in_range ? sfrt_pkg::OP_ADD : sfrt_pkg::OP_REJECT;
      end
      sfrt_pkg::ACT_CHECK: begin
        req.op = in_range ? sfrt_pkg::OP_CHECK : sfrt_pkg::OP_ALLOW;
      end
      default: begin
        req.op = in_range ? sfrt_pkg::OP_GET : sfrt_pkg::OP_GET_NONE;
      end
    endcase
  end

  assign in_ready_o = (cnt_q != 2'd2) && !hold_i;
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_head_o   = ent_q[rd_q];

  always_comb begin
    wr_d  = push ? !wr_q : wr_q;
    rd_d  = q_pop_i ? !rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, q_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_q] <= req;
    end
  end

endmodule

@@ rtl/core/sfrt_back.sv @@
module sfrt_back #(
  parameter int NumProcesses    = sfrt_pkg::NUM_PROCESSES,
  parameter int RulesPerProcess = sfrt_pkg::RULES_PER_PROCESS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sfrt_pkg::cfg_t                 cfg_i,
  input  logic                           q_valid_i,
  input  sfrt_pkg::req_t                 q_head_i,
  output logic                           q_pop_o,
  output logic                           clearing_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     status_o,
  output logic [sfrt_pkg::VERDICT_W-1:0] verdict_o,
  output logic [1:0]                     current_mode_o
);

  localparam int PidW      = (NumProcesses > 1) ? $clog2(NumProcesses) : 1;
  localparam int RuleDepth = NumProcesses * RulesPerProcess;
  localparam int AddrW     = $clog2(RuleDepth);
  localparam int CntW      = $clog2(RulesPerProcess + 1);
  localparam int ProcW     = 2 + CntW;
  localparam int RuleW     = sfrt_pkg::RULE_W;
  localparam int VerW      = sfrt_pkg::VERDICT_W;

  localparam logic [2:0] S_CLR    = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_LOOK   = 3'd2;
  localparam logic [2:0] S_STRICT = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_RESP   = 3'd5;

  logic [2:0]      state_q, state_d;
  sfrt_pkg::req_t  req_q, req_d;
  logic [AddrW-1:0] base_q, base_d;
  logic [1:0]      mode_q, mode_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            pend_q, pend_d;
  logic [PidW-1:0] clr_q, clr_d;
  logic [1:0]      res_status_q, res_status_d;
  logic [VerW-1:0] res_verdict_q, res_verdict_d;
  logic [1:0]      res_mode_q, res_mode_d;
  logic            out_valid_q, out_valid_d;
  logic [1:0]      out_status_q, out_status_d;
  logic [VerW-1:0] out_verdict_q, out_verdict_d;
  logic [1:0]      out_mode_q, out_mode_d;

  logic             proc_we;
  logic [PidW-1:0]  proc_waddr, proc_raddr;
  logic [ProcW-1:0] proc_wdata, proc_rdata;
  logic             rule_we;
  logic [AddrW-1:0] rule_waddr, rule_raddr;
  logic [RuleW-1:0] rule_wdata, rule_rdata;
  logic             q_pop;

  logic [1:0]      pm;
  logic [CntW-1:0] pc;
  logic            hit;
  logic            issue;

  sfrt_ram #(.Width(ProcW), .Depth(NumProcesses)) u_proc_ram (
    .clk_i   (clk_i),
    .we_i    (proc_we),
    .waddr_i (proc_waddr),
    .wdata_i (proc_wdata),
    .raddr_i (proc_raddr),
    .rdata_o (proc_rdata)
  );

  sfrt_ram #(.Width(RuleW), .Depth(RuleDepth)) u_rule_ram (
    .clk_i   (clk_i),
    .we_i    (rule_we),
    .waddr_i (rule_waddr),
    .wdata_i (rule_wdata),
    .raddr_i (rule_raddr),
    .rdata_o (rule_rdata)
  );

  assign pm    = proc_rdata[ProcW-1:CntW];
  assign pc    = proc_rdata[CntW-1:0];
  assign hit   = pend_q && (rule_rdata[RuleW-1:VerW] == req_q.syscall);
  assign issue = idx_q < cnt_q;

  always_comb begin
    state_d       = state_q;
    req_d         = req_q;
    base_d        = base_q;
    mode_d        = mode_q;
    cnt_d         = cnt_q;
    idx_d         = idx_q;
    pend_d        = 1'b0;
    clr_d         = clr_q;
    res_status_d  = res_status_q;
    res_verdict_d = res_verdict_q;
    res_mode_d    = res_mode_q;
    out_valid_d   = out_valid_q;
    out_status_d  = out_status_q;
    out_verdict_d = out_verdict_q;
    out_mode_d    = out_mode_q;
    proc_we       = 1'b0;
    proc_waddr    = req_q.pid[PidW-1:0];
    proc_wdata    = '0;
    proc_raddr    = q_head_i.pid[PidW-1:0];
    rule_we       = 1'b0;
    rule_waddr    = base_q + AddrW'(idx_q);
    rule_wdata    = {sfrt_pkg::strict_syscall(idx_q[1:0]), cfg_i.allow_code};
    rule_raddr    = base_q + AddrW'(idx_q);
    q_pop         = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLR: begin
        proc_we    = 1'b1;
        proc_waddr = clr_q;
        clr_d      = clr_q + PidW'(1);
        if (clr_q == PidW'(NumProcesses - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop   = 1'b1;
          req_d   = q_head_i;
          base_d  = AddrW'(q_head_i.pid[PidW-1:0]) * AddrW'(RulesPerProcess);
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        res_status_d  = sfrt_pkg::ST_OK;
        res_verdict_d = '0;
        res_mode_d    = sfrt_pkg::MODE_DISABLED;
        state_d       = S_RESP;
        case (req_q.op)
          sfrt_pkg::OP_SET_STRICT: begin
            idx_d   = '0;
            state_d = S_STRICT;
          end
          sfrt_pkg::OP_SET_FILTER: begin
            proc_we    = 1'b1;
            proc_wdata = {sfrt_pkg::MODE_FILTER, pc};
          end
          sfrt_pkg::OP_SET_DISABLED: begin
            proc_we    = 1'b1;
            proc_wdata = {sfrt_pkg::MODE_DISABLED, CntW'(0)};
          end
          sfrt_pkg::OP_ADD: begin
            if (pm != sfrt_pkg::MODE_FILTER) begin
              res_status_d = sfrt_pkg::ST_REJECT;
            end else if (pc >= CntW'(RulesPerProcess)) begin
              res_status_d = sfrt_pkg::ST_FULL;
            end else begin
              rule_we    = 1'b1;
              rule_waddr = base_q + AddrW'(pc);
              rule_wdata = {req_q.syscall, req_q.rule_verdict};
              proc_we    = 1'b1;
              proc_wdata = {pm, pc + CntW'(1)};
            end
          end
          sfrt_pkg::OP_CHECK: begin
            if (pm == sfrt_pkg::MODE_DISABLED) begin
              res_verdict_d = cfg_i.allow_code;
            end else begin
              mode_d  = pm;
              cnt_d   = pc;
              idx_d   = '0;
              state_d = S_SCAN;
            end
          end
          sfrt_pkg::OP_ALLOW: begin
            res_verdict_d = cfg_i.allow_code;
          end
          sfrt_pkg::OP_GET: begin
            res_mode_d = pm;
          end
          sfrt_pkg::OP_GET_NONE: begin
            res_mode_d = sfrt_pkg::MODE_DISABLED;
          end
          default: begin
            res_status_d = sfrt_pkg::ST_REJECT;
          end
        endcase
      end
      S_STRICT: begin
        rule_we = 1'b1;
        idx_d   = idx_q + CntW'(1);
        if (idx_q == CntW'(3)) begin
          proc_we       = 1'b1;
          proc_wdata    = {sfrt_pkg::MODE_STRICT, CntW'(4)};
          res_status_d  = sfrt_pkg::ST_OK;
          res_verdict_d = '0;
          res_mode_d    = sfrt_pkg::MODE_DISABLED;
          state_d       = S_RESP;
        end
      end
      S_SCAN: begin
        if (hit) begin
          res_verdict_d = rule_rdata[VerW-1:0];
          state_d       = S_RESP;
        end else if (!issue) begin
          res_verdict_d = (mode_q == sfrt_pkg::MODE_STRICT) ? cfg_i.kill_code
                                                             : cfg_i.allow_code;
          state_d       = S_RESP;
        end else begin
          pend_d = 1'b1;
          idx_d  = idx_q + CntW'(1);
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d   = 1'b1;
          out_status_d  = res_status_q;
          out_verdict_d = res_verdict_q;
          out_mode_d    = res_mode_q;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q         <= req_d;
    base_q        <= base_d;
    mode_q        <= mode_d;
    cnt_q         <= cnt_d;
    idx_q         <= idx_d;
    res_status_q  <= res_status_d;
    res_verdict_q <= res_verdict_d;
    res_mode_q    <= res_mode_d;
    out_status_q  <= out_status_d;
    out_verdict_q <= out_verdict_d;
    out_mode_q    <= out_mode_d;
  end

  assign q_pop_o        = q_pop;
  assign clearing_o     = (state_q == S_CLR);
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign verdict_o      = out_verdict_q;
  assign current_mode_o = out_mode_q;

`ifndef SYNTHESIS
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> cnt_q <= CntW'(RulesPerProcess))
    else $error("scan length beyond rule list");

  a_rule_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rule_we |-> (state_q == S_STRICT || state_q == S_LOOK))
    else $error("rule write outside add or strict load");

  a_strict_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STRICT && idx_q == CntW'(3)) |=> state_q == S_RESP)
    else $error("strict load not four entries");

  a_resp_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && (!out_valid_q || out_ready_i))
      |=> (out_valid_q && state_q == S_IDLE))
    else $error("result not moved to output");

  a_no_pop_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR || state_q == S_SCAN) |-> !q_pop_o)
    else $error("queue popped while busy");
`endif

endmodule
